// ----- hw/rtl/pllt_pkg.sv -----
// Package for the PLL tuning register calculator.
// Holds field widths, band codes, per-band constants and the shared item types.
// No dependencies; every other file in hw/rtl refers to it by scoped names.
package pllt_pkg;

   localparam int FREQ_W  = 26;
   localparam int SEL_W   = 3;
   localparam int STEP_W  = 15;
   localparam int C_W     = 15;
   localparam int RS_W    = 18;
   localparam int RP_W    = 21;
   localparam int QE_W    = 16;
   localparam int P_W     = 15;
   localparam int PROD_W  = 35;
   localparam int PB_W    = P_W - 1;
   localparam int RECIP_SH = 26;

   localparam int XTAL_HZ_DEFAULT = 10000000;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [FREQ_W-1:0] FREQ_MIN  = FREQ_W'(130000);
   localparam logic [FREQ_W-1:0] EDGE_MF   = FREQ_W'(800000);
   localparam logic [FREQ_W-1:0] EDGE_HF1  = FREQ_W'(3200000);
   localparam logic [FREQ_W-1:0] EDGE_HF2  = FREQ_W'(8000000);
   localparam logic [FREQ_W-1:0] EDGE_HF3  = FREQ_W'(16000000);
   localparam logic [FREQ_W-1:0] FREQ_MAX  = FREQ_W'(30000000);

   localparam int STEP_LF  = 500;
   localparam int STEP_MF  = 2000;
   localparam int STEP_HF1 = 5000;
   localparam int STEP_HF2 = 10000;
   localparam int STEP_HF3 = 25000;

   localparam int N_LF  = 100;
   localparam int N_MF  = 25;
   localparam int N_HF1 = 10;
   localparam int N_HF2 = 5;
   localparam int N_HF3 = 4;

   localparam int Q_LOW  = 48;
   localparam int Q_HIGH = 23;

   localparam int C_LF  = 4 * N_LF  * (Q_LOW + 2);
   localparam int C_MF  = 4 * N_MF  * (Q_LOW + 2);
   localparam int C_HF1 = 4 * N_HF1 * (Q_LOW + 2);
   localparam int C_HF2 = 4 * N_HF2 * (Q_LOW + 2);
   localparam int C_HF3 = 4 * N_HF3 * (Q_HIGH + 2);

   localparam longint RS_LF  = (64'd1 << RECIP_SH) / STEP_LF;
   localparam longint RS_MF  = (64'd1 << RECIP_SH) / STEP_MF;
   localparam longint RS_HF1 = (64'd1 << RECIP_SH) / STEP_HF1;
   localparam longint RS_HF2 = (64'd1 << RECIP_SH) / STEP_HF2;
   localparam longint RS_HF3 = (64'd1 << RECIP_SH) / STEP_HF3;

   localparam logic [7:0] REG40_BASE = 8'hC0;
   localparam logic [7:0] CLK_EN_REF = 8'h24;
   localparam logic [7:0] CLK_EN_STD = 8'h20;
   localparam logic [SEL_W-1:0] SEL_CAL = SEL_W'(7);

   localparam logic [P_W-1:0] PUMP_T0 = P_W'(45);
   localparam logic [P_W-1:0] PUMP_T1 = P_W'(480);
   localparam logic [P_W-1:0] PUMP_T2 = P_W'(640);
   localparam logic [P_W-1:0] PUMP_T3 = P_W'(800);
   localparam logic [P_W-1:0] P_MIN   = P_W'(8);
   localparam logic [PB_W-1:0] PB_OFFSET = PB_W'(4);

   typedef enum logic [2:0] {
      BAND_LF,
      BAND_MF,
      BAND_HF1,
      BAND_HF2,
      BAND_HF3
   } band_type;

   typedef struct packed {
      logic [FREQ_W-1:0] req;
      logic [FREQ_W-1:0] cur;
      band_type          band;
      logic              oor;
   } item_type;

   typedef struct packed {
      logic [FREQ_W-1:0] new_freq_hz;
      logic              out_of_range;
      logic [7:0]        reg_40;
      logic [7:0]        reg_41;
      logic [7:0]        reg_42;
      logic [7:0]        reg_09;
      logic [6:0]        div_n1;
   } result_type;

   function automatic logic [STEP_W-1:0] band_step(band_type band);
      logic [STEP_W-1:0] v;
      unique case (band)
         BAND_LF:  v = STEP_W'(STEP_LF);
         BAND_MF:  v = STEP_W'(STEP_MF);
         BAND_HF1: v = STEP_W'(STEP_HF1);
         BAND_HF2: v = STEP_W'(STEP_HF2);
         BAND_HF3: v = STEP_W'(STEP_HF3);
         default:  v = STEP_W'(STEP_LF);
      endcase
      return v;
   endfunction

   function automatic logic [RS_W-1:0] band_rs(band_type band);
      logic [RS_W-1:0] v;
      unique case (band)
         BAND_LF:  v = RS_W'(RS_LF);
         BAND_MF:  v = RS_W'(RS_MF);
         BAND_HF1: v = RS_W'(RS_HF1);
         BAND_HF2: v = RS_W'(RS_HF2);
         BAND_HF3: v = RS_W'(RS_HF3);
         default:  v = RS_W'(RS_LF);
      endcase
      return v;
   endfunction

   function automatic logic [C_W-1:0] band_c(band_type band);
      logic [C_W-1:0] v;
      unique case (band)
         BAND_LF:  v = C_W'(C_LF);
         BAND_MF:  v = C_W'(C_MF);
         BAND_HF1: v = C_W'(C_HF1);
         BAND_HF2: v = C_W'(C_HF2);
         BAND_HF3: v = C_W'(C_HF3);
         default:  v = C_W'(C_LF);
      endcase
      return v;
   endfunction

   function automatic logic [6:0] band_n(band_type band);
      logic [6:0] v;
      unique case (band)
         BAND_LF:  v = 7'(N_LF);
         BAND_MF:  v = 7'(N_MF);
         BAND_HF1: v = 7'(N_HF1);
         BAND_HF2: v = 7'(N_HF2);
         BAND_HF3: v = 7'(N_HF3);
         default:  v = 7'(N_LF);
      endcase
      return v;
   endfunction

   function automatic logic [6:0] band_q(band_type band);
      logic [6:0] v;
      unique case (band)
         BAND_HF3: v = 7'(Q_HIGH);
         default:  v = 7'(Q_LOW);
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/pllt_front.sv -----
// Front end of the PLL tuning register calculator: range check and band selection.
// Depends on pllt_pkg for the band thresholds and the queue item type.
module pllt_front (
   input  logic [pllt_pkg::FREQ_W-1:0] requested_hz,
   input  logic [pllt_pkg::FREQ_W-1:0] current_hz,
   output pllt_pkg::item_type          item
);

   pllt_pkg::band_type band;
   logic               oor;

   always_comb begin
      oor  = 1'b0;
      band = pllt_pkg::BAND_LF;
      priority if (requested_hz < pllt_pkg::FREQ_MIN) begin
         oor = 1'b1;
      end else if (requested_hz < pllt_pkg::EDGE_MF) begin
         band = pllt_pkg::BAND_LF;
      end else if (requested_hz < pllt_pkg::EDGE_HF1) begin
         band = pllt_pkg::BAND_MF;
      end else if (requested_hz < pllt_pkg::EDGE_HF2) begin
         band = pllt_pkg::BAND_HF1;
      end else if (requested_hz < pllt_pkg::EDGE_HF3) begin
         band = pllt_pkg::BAND_HF2;
      end else if (requested_hz < pllt_pkg::FREQ_MAX) begin
         band = pllt_pkg::BAND_HF3;
      end else begin
         oor = 1'b1;
      end
   end

   assign item.req  = requested_hz;
   assign item.cur  = current_hz;
   assign item.band = band;
   assign item.oor  = oor;

endmodule

// ----- hw/rtl/pllt_queue.sv -----
// Short FIFO of classified items between the front end and the arithmetic back end.
// Depends on pllt_pkg for the item type and the default depth.
module pllt_queue #(
   parameter int DEPTH = pllt_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  pllt_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output pllt_pkg::item_type pop_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   pllt_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count exceeds depth");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count did not grow on a lone push");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue fill count did not shrink on a lone pop");
`endif

endmodule

// ----- hw/rtl/pllt_back.sv -----
// Back end of the PLL tuning register calculator: four-stage arithmetic pipeline.
// Stage 4 is the output register. Depends on pllt_pkg for widths and band tables.
module pllt_back #(
   parameter int XTAL_HZ = pllt_pkg::XTAL_HZ_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  pllt_pkg::item_type           in_item,
   input  logic [pllt_pkg::SEL_W-1:0]   input_select,
   output logic                         out_valid,
   input  logic                         out_ready,
   output pllt_pkg::result_type         out_result
);

   localparam int FW  = pllt_pkg::FREQ_W;
   localparam int SH  = pllt_pkg::RECIP_SH;
   localparam int PW  = pllt_pkg::P_W;
   localparam int PRW = pllt_pkg::PROD_W;
   localparam int PBW = pllt_pkg::PB_W;

   localparam longint RP_LF  = (longint'(pllt_pkg::C_LF)  << SH) / XTAL_HZ;
   localparam longint RP_MF  = (longint'(pllt_pkg::C_MF)  << SH) / XTAL_HZ;
   localparam longint RP_HF1 = (longint'(pllt_pkg::C_HF1) << SH) / XTAL_HZ;
   localparam longint RP_HF2 = (longint'(pllt_pkg::C_HF2) << SH) / XTAL_HZ;
   localparam longint RP_HF3 = (longint'(pllt_pkg::C_HF3) << SH) / XTAL_HZ;
   localparam logic [FW-1:0]  XTAL_V  = FW'(XTAL_HZ);
   localparam logic [PRW-1:0] XTAL_PR = PRW'(XTAL_HZ);

   logic en;

   // Stage 1: reciprocal estimates and the exact P numerator.
   logic                   v1_ff;
   logic [FW-1:0]          req1_ff, cur1_ff;
   pllt_pkg::band_type     band1_ff;
   logic                   oor1_ff;
   logic [pllt_pkg::QE_W-1:0] qe1_ff, qe1_in;
   logic [PW-1:0]          pe1_ff, pe1_in;
   logic [PRW-1:0]         prod1_ff, prod1_in;
   logic [pllt_pkg::RP_W-1:0] rp;
   logic [FW+pllt_pkg::RS_W-1:0] mq;
   logic [FW+pllt_pkg::RP_W-1:0] mp;
   logic [FW+pllt_pkg::C_W-1:0]  mc;

   // Stage 2: multiply the estimates back.
   logic                   v2_ff;
   logic [FW-1:0]          req2_ff, cur2_ff;
   pllt_pkg::band_type     band2_ff;
   logic                   oor2_ff;
   logic [PW-1:0]          pe2_ff;
   logic [PRW-1:0]         prod2_ff;
   logic [FW-1:0]          qs2_ff, qs2_in;
   logic [PRW-1:0]         px2_ff, px2_in;
   logic [pllt_pkg::QE_W+pllt_pkg::STEP_W-1:0] ms;
   logic [PW+FW-1:0]       mx;

   // Stage 3: one correction step on both quotients.
   logic                   v3_ff;
   logic [FW-1:0]          cur3_ff;
   pllt_pkg::band_type     band3_ff;
   logic                   oor3_ff;
   logic [FW-1:0]          base3_ff, base3_in;
   logic                   inexact3_ff, inexact3_in;
   logic                   up3_ff, up3_in;
   logic [PW-1:0]          p3_ff, p3_in;
   logic [FW-1:0]          rem_s;
   logic [FW-1:0]          step3;
   logic [PRW-1:0]         rem_p;

   // Stage 4: result register.
   logic                   v4_ff;
   pllt_pkg::result_type   res4_ff, res4_in;
   logic [FW-1:0]          step4;
   logic [PBW-1:0]         pb;
   logic [2:0]             pump;
   logic [7:0]             pb_hi;

   assign en        = !v4_ff || out_ready;
   assign in_ready  = en;
   assign out_valid = v4_ff;
   assign out_result = res4_ff;

   always_comb begin
      unique case (in_item.band)
         pllt_pkg::BAND_LF:  rp = pllt_pkg::RP_W'(RP_LF);
         pllt_pkg::BAND_MF:  rp = pllt_pkg::RP_W'(RP_MF);
         pllt_pkg::BAND_HF1: rp = pllt_pkg::RP_W'(RP_HF1);
         pllt_pkg::BAND_HF2: rp = pllt_pkg::RP_W'(RP_HF2);
         pllt_pkg::BAND_HF3: rp = pllt_pkg::RP_W'(RP_HF3);
         default:            rp = pllt_pkg::RP_W'(RP_LF);
      endcase
      mq = (FW + pllt_pkg::RS_W)'(in_item.req)
         * (FW + pllt_pkg::RS_W)'(pllt_pkg::band_rs(in_item.band));
      mp = (FW + pllt_pkg::RP_W)'(in_item.req) * (FW + pllt_pkg::RP_W)'(rp);
      mc = (FW + pllt_pkg::C_W)'(in_item.req)
         * (FW + pllt_pkg::C_W)'(pllt_pkg::band_c(in_item.band));
      qe1_in   = mq[SH +: pllt_pkg::QE_W];
      pe1_in   = mp[SH +: PW];
      prod1_in = mc[PRW-1:0];
   end

   always_comb begin
      ms = (pllt_pkg::QE_W + pllt_pkg::STEP_W)'(qe1_ff)
         * (pllt_pkg::QE_W + pllt_pkg::STEP_W)'(pllt_pkg::band_step(band1_ff));
      mx = (PW + FW)'(pe1_ff) * (PW + FW)'(XTAL_V);
      qs2_in = ms[FW-1:0];
      px2_in = mx[PRW-1:0];
   end

   always_comb begin
      step3 = FW'(pllt_pkg::band_step(band2_ff));
      rem_s = req2_ff - qs2_ff;
      if (rem_s >= step3) begin
         base3_in    = qs2_ff + step3;
         inexact3_in = (rem_s != step3);
      end else begin
         base3_in    = qs2_ff;
         inexact3_in = (rem_s != '0);
      end
      up3_in = (req2_ff > cur2_ff);
      rem_p  = prod2_ff - px2_ff;
      p3_in  = pe2_ff + PW'(rem_p >= XTAL_PR);
   end

   always_comb begin
      step4 = FW'(pllt_pkg::band_step(band3_ff));
      pb    = (p3_ff < pllt_pkg::P_MIN) ? '0 : PBW'(p3_ff >> 1) - pllt_pkg::PB_OFFSET;
      priority if (p3_ff < pllt_pkg::PUMP_T0) begin
         pump = 3'd0;
      end else if (p3_ff < pllt_pkg::PUMP_T1) begin
         pump = 3'd1;
      end else if (p3_ff < pllt_pkg::PUMP_T2) begin
         pump = 3'd2;
      end else if (p3_ff < pllt_pkg::PUMP_T3) begin
         pump = 3'd3;
      end else begin
         pump = 3'd4;
      end
      pb_hi = 8'(pb >> 8);
      res4_in = '0;
      if (oor3_ff) begin
         res4_in.new_freq_hz  = cur3_ff;
         res4_in.out_of_range = 1'b1;
      end else begin
         res4_in.new_freq_hz = (inexact3_ff && up3_ff) ? base3_ff + step4 : base3_ff;
         res4_in.reg_40      = pllt_pkg::REG40_BASE | {3'b000, pump, 2'b00} | pb_hi;
         res4_in.reg_41      = pb[7:0];
         res4_in.reg_42      = {p3_ff[0], pllt_pkg::band_q(band3_ff)};
         res4_in.reg_09      = (input_select == pllt_pkg::SEL_CAL) ?
                               pllt_pkg::CLK_EN_REF : pllt_pkg::CLK_EN_STD;
         res4_in.div_n1      = pllt_pkg::band_n(band3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         req1_ff     <= in_item.req;
         cur1_ff     <= in_item.cur;
         band1_ff    <= in_item.band;
         oor1_ff     <= in_item.oor;
         qe1_ff      <= qe1_in;
         pe1_ff      <= pe1_in;
         prod1_ff    <= prod1_in;
         req2_ff     <= req1_ff;
         cur2_ff     <= cur1_ff;
         band2_ff    <= band1_ff;
         oor2_ff     <= oor1_ff;
         pe2_ff      <= pe1_ff;
         prod2_ff    <= prod1_ff;
         qs2_ff      <= qs2_in;
         px2_ff      <= px2_in;
         cur3_ff     <= cur2_ff;
         band3_ff    <= band2_ff;
         oor3_ff     <= oor2_ff;
         base3_ff    <= base3_in;
         inexact3_ff <= inexact3_in;
         up3_ff      <= up3_in;
         p3_ff       <= p3_in;
         res4_ff     <= res4_in;
      end
   end

`ifndef SYNTHESIS
   a_oor_clears_regs: assert property (@(posedge clock) disable iff (reset)
      v4_ff && res4_ff.out_of_range |->
         res4_ff.reg_40 == '0 && res4_ff.reg_42 == '0 && res4_ff.div_n1 == '0)
      else $error("out-of-range result carries register values");
   a_q_field: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !res4_ff.out_of_range |->
         res4_ff.reg_42[6:0] == 7'(pllt_pkg::Q_LOW) ||
         res4_ff.reg_42[6:0] == 7'(pllt_pkg::Q_HIGH))
      else $error("reference divider field is not a band value");
   a_q_matches_n: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !res4_ff.out_of_range && res4_ff.div_n1 == 7'(pllt_pkg::N_HF3) |->
         res4_ff.reg_42[6:0] == 7'(pllt_pkg::Q_HIGH))
      else $error("top band divider paired with the wrong reference divider");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !out_ready |=> v4_ff && $stable(res4_ff))
      else $error("result register changed while stalled");
`endif

endmodule

// ----- hw/rtl/pll_tuning_register_calc.sv -----
// Top level of the PLL tuning register calculator.
// Instantiates pllt_front, pllt_queue and pllt_back; uses pllt_pkg for types.
//
// The block turns a requested and a current tuning frequency into the step-aligned
// new frequency and the PLL divider register bytes. It takes one request per clock
// cycle while the queue has room, and returns one result per request, in order.
// Each result passes through the four-stage arithmetic back end, whose stages hold
// the reciprocal multiplies, their back-multiplies, a single correction step and
// the result register. A queue of QUEUE_DEPTH items between the band classifier
// and the back end keeps requests flowing while the rsp side stalls, until it fills.
// The input_select register is written through csr_wr_en and csr_wr_data and
// should only change while no request is in flight.
module pll_tuning_register_calc #(
   parameter int XTAL_HZ     = pllt_pkg::XTAL_HZ_DEFAULT,
   parameter int QUEUE_DEPTH = pllt_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   // requested_hz [25:0], current_hz [51:26], zero fill [55:52]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_freq_hz [25:0], reg_40 [33:26], reg_41 [41:34], reg_42 [49:42],
   // reg_09 [57:50], div_n1 [64:58], zero fill [71:65]
   output logic [71:0] rsp_tdata,
   // out_of_range [0]
   output logic [0:0]  rsp_tuser
);

   logic [pllt_pkg::SEL_W-1:0] input_select_ff, input_select_in;
   pllt_pkg::item_type   front_item;
   pllt_pkg::item_type   queue_item;
   logic                 queue_valid;
   logic                 back_ready;
   pllt_pkg::result_type result;

   always_comb begin
      input_select_in = input_select_ff;
      if (csr_wr_en) begin
         input_select_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_select_ff <= '0;
      end else begin
         input_select_ff <= input_select_in;
      end
   end

   pllt_front u_front (
      .requested_hz (req_tdata[25:0]),
      .current_hz   (req_tdata[51:26]),
      .item         (front_item)
   );

   pllt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_item   (queue_item)
   );

   pllt_back #(
      .XTAL_HZ (XTAL_HZ)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (queue_valid),
      .in_ready     (back_ready),
      .in_item      (queue_item),
      .input_select (input_select_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_result   (result)
   );

   assign rsp_tdata = {7'b0000000, result.div_n1, result.reg_09, result.reg_42,
                       result.reg_41, result.reg_40, result.new_freq_hz};
   assign rsp_tuser = result.out_of_range;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Testbench for pll_tuning_register_calc: drives tuning requests on the req stream
// and checks every rsp transfer against a predictor held in a scoreboard class.
// Depends on pllt_pkg for the result layout and the clock-enable constants.
module tb;
   import pllt_pkg::*;

   localparam int PERIOD          = 4;
   localparam int XTAL            = 10000000;
   localparam int LIMIT           = 300000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int LONG_HOLD       = 80;
   localparam int NUM_DIRECTED    = 22;

   localparam int unsigned BAND_EDGES [6] = '{130000, 800000, 3200000, 8000000,
                                              16000000, 30000000};
   localparam int unsigned DIR_REQ [NUM_DIRECTED] = '{
      0, 129999, 130000, 130001, 130001, 799999, 800000, 800001,
      3199999, 3200000, 7999999, 8000000, 8000001, 15999999, 16000000, 16010000,
      29999999, 29999999, 30000000, 67108863, 250000, 1000};
   localparam int unsigned DIR_CUR [NUM_DIRECTED] = '{
      0, 67108863, 0, 0, 200000, 0, 800000, 800001,
      0, 0, 9000000, 0, 8000000, 0, 0, 0,
      0, 29999999, 12345, 67108863, 100, 1};
   localparam int          PHASE_IDLE [4]   = '{0, 69, 0, 12};
   localparam int          PHASE_STALL [4]  = '{0, 0, 69, 12};
   localparam logic [2:0]  PHASE_SELECT [4] = '{3'd7, 3'd2, 3'd5, 3'd0};

   class tuning_scoreboard;
      result_type  expected_q[$];
      logic [2:0]  input_select;
      int          errors;
      int          requests_seen;
      int          results_seen;
      int          oor_seen;

      function new();
         input_select  = '0;
         errors        = 0;
         requests_seen = 0;
         results_seen  = 0;
         oor_seen      = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function result_type tuning_result(logic [25:0] req, logic [25:0] cur);
         result_type      r;
         longint unsigned n, q, step, aligned, p, p0, pb, pump;
         r = '0;
         if (req < 130000 || req >= 30000000) begin
            r.new_freq_hz  = cur;
            r.out_of_range = 1'b1;
            return r;
         end
         if (req < 800000) begin
            n = 100; q = 48; step = 500;
         end else if (req < 3200000) begin
            n = 25; q = 48; step = 2000;
         end else if (req < 8000000) begin
            n = 10; q = 48; step = 5000;
         end else if (req < 16000000) begin
            n = 5; q = 48; step = 10000;
         end else begin
            n = 4; q = 23; step = 25000;
         end
         aligned = (req / step) * step;
         if (aligned != req && req > cur)
            aligned += step;
         p  = (req * 64'd4 * n * (q + 2)) / XTAL;
         p0 = p & 1;
         pb = (p < 8) ? 0 : ((p - p0) / 2 - 4);
         if (p < 45)       pump = 0;
         else if (p < 480) pump = 1;
         else if (p < 640) pump = 2;
         else if (p < 800) pump = 3;
         else              pump = 4;
         r.new_freq_hz = 26'(aligned);
         r.reg_40      = 8'((pb >> 8) | (pump << 2) | REG40_BASE);
         r.reg_41      = 8'(pb);
         r.reg_42      = 8'((p0 << 7) | q);
         r.reg_09      = (input_select == SEL_CAL) ? CLK_EN_REF : CLK_EN_STD;
         r.div_n1      = 7'(n);
         return r;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         if (errors < 40)
            $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
         errors++;
      endtask

      function void note_request(logic [25:0] req, logic [25:0] cur);
         expected_q.push_back(tuning_result(req, cur));
         requests_seen++;
      endfunction

      task check_result(logic [71:0] data, logic oor);
         result_type want;
         if (expected_q.size() == 0) begin
            report("rsp transfer with no request outstanding", data[31:0], '0);
            return;
         end
         want = expected_q.pop_front();
         results_seen++;
         if (want.out_of_range)
            oor_seen++;
         if (data[25:0] !== want.new_freq_hz)  report("new_freq_hz", data[25:0], want.new_freq_hz);
         if (oor !== want.out_of_range)        report("out_of_range", oor, want.out_of_range);
         if (data[33:26] !== want.reg_40)      report("reg_40", data[33:26], want.reg_40);
         if (data[41:34] !== want.reg_41)      report("reg_41", data[41:34], want.reg_41);
         if (data[49:42] !== want.reg_42)      report("reg_42", data[49:42], want.reg_42);
         if (data[57:50] !== want.reg_09)      report("reg_09", data[57:50], want.reg_09);
         if (data[64:58] !== want.div_n1)      report("div_n1", data[64:58], want.div_n1);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   tuning_scoreboard sb = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int stall_left     = 0;
   int cycles         = 0;

   pll_tuning_register_calc u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #(PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycles, sb.pending());
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid === 1'b1 && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser[0]);
         if (req_tvalid && req_tready === 1'b1)
            sb.note_request(req_tdata[25:0], req_tdata[51:26]);
      end
   end

   // The rsp side; a long hold-off requested by the stimulus takes precedence.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [25:0] pick_request();
      int unsigned kind, lo, hi, stp, v;
      band_type    band;
      kind = $urandom_range(99);
      if (kind < 8)
         return 26'($urandom_range(129999));
      if (kind < 16)
         return 26'($urandom_range(67108863, 30000000));
      if (kind < 26)
         return 26'(BAND_EDGES[$urandom_range(5)] + $urandom_range(6) - 3);
      band = band_type'($urandom_range(4));
      case (band)
         BAND_LF: begin
            lo = 130000; hi = 799999; stp = 500;
         end
         BAND_MF: begin
            lo = 800000; hi = 3199999; stp = 2000;
         end
         BAND_HF1: begin
            lo = 3200000; hi = 7999999; stp = 5000;
         end
         BAND_HF2: begin
            lo = 8000000; hi = 15999999; stp = 10000;
         end
         default: begin
            lo = 16000000; hi = 29999999; stp = 25000;
         end
      endcase
      v = $urandom_range(hi, lo);
      if ($urandom_range(3) == 0)
         v -= v % stp;
      return 26'(v);
   endfunction

   function automatic logic [25:0] pick_current(logic [25:0] req);
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 25)
         return req;
      if (kind < 60)
         return 26'(req + $urandom_range(50000) - 25000);
      if (kind < 85)
         return 26'($urandom_range(30000000));
      return 26'($urandom);
   endfunction

   // Entered and left at a falling edge; the item stays offered until accepted.
   task automatic send_item(logic [25:0] req, logic [25:0] cur);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, cur, req};
      do @(posedge clock); while (req_tready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic settle(int sender_pct, int receiver_pct, int hold);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      stall_left     = hold;
      @(negedge clock);
   endtask

   task automatic write_select(logic [2:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.input_select = value;
   endtask

   initial begin
      logic [25:0] req;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_DIRECTED; i++)
         send_item(26'(DIR_REQ[i]), 26'(DIR_CUR[i]));
      for (int ph = 0; ph < 4; ph++) begin
         settle(PHASE_IDLE[ph], PHASE_STALL[ph], (ph == 0) ? LONG_HOLD : 0);
         write_select(PHASE_SELECT[ph]);
         repeat (ITEMS_PER_PHASE) begin
            req = pick_request();
            send_item(req, pick_current(req));
         end
      end
      settle(0, 0, 0);
      $display("Checked %0d results for %0d requests, %0d of them out of range.",
               sb.results_seen, sb.requests_seen, sb.oor_seen);
      $display("Band edges and rounding cases, input select 0, 7, 2 and 5, and a full pipeline.");
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
